>>> design/pbns_pkg.sv
// Shared constants, types and helpers for the pending bitmap seed search block.
package pbns_pkg;

	localparam int WORD_BITS = 32;
	localparam int WORD_LOG  = 5;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_MARK = 1'b1;

	typedef logic [WORD_BITS-1:0] word_t;

	// Lowest set bit of a word; returns 0 for an all-zero word.
	function automatic logic [WORD_LOG-1:0] first_set(input word_t bits);
		logic [WORD_LOG-1:0] pos;
		pos = '0;
		for (int j = WORD_BITS - 1; j >= 0; j--) begin
			if (bits[j]) begin
				pos = WORD_LOG'(j);
			end
		end
		return pos;
	endfunction

endpackage

>>> design/pending_bitmap_next_seed.sv
// Pending bitmap with load/mark updates and a word-serial find-next-set search.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready   | operation, entry_index, pending_bit, last_of_group
//  out     | output    | out_valid / out_ready | seed_found, seed_index
//
// An item without last_of_group reads its word at transfer, then writes it back.
// With last_of_group a seek state and a word-by-word scan of 32-entry bitmap words follow,
// all through the single bitmap memory port, then the done state; scan words = 1 + words skipped.
// The bitmap has no reset; entries read before being loaded return arbitrary data.
// A finished result waits in the output register; a new item can run meanwhile and
// its own result stalls in the done state until out is free.
module pending_bitmap_next_seed
	import pbns_pkg::*;
#(
	parameter int MAX_ENTRIES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [15:0] entry_index,
	input  logic        pending_bit,
	input  logic        last_of_group,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        seed_found,
	output logic [15:0] seed_index
);

	localparam int CLOG_W    = $clog2(MAX_ENTRIES) + 1;
	localparam int POS_W     = (CLOG_W > 17) ? CLOG_W : 17;
	localparam int WA_W      = POS_W - WORD_LOG;
	localparam int NUM_WORDS = (MAX_ENTRIES + WORD_BITS - 1) / WORD_BITS;
	localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int TAIL_BITS = MAX_ENTRIES % WORD_BITS;

	localparam logic [POS_W-1:0] MAX_POS   = POS_W'(MAX_ENTRIES);
	localparam logic [WA_W-1:0]  LAST_WORD = WA_W'(NUM_WORDS - 1);
	localparam word_t TAIL_MASK = (TAIL_BITS == 0) ? '1 :
		WORD_BITS'((64'(1) << TAIL_BITS) - 64'(1));

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_WR   = 3'd1;
	localparam logic [2:0] S_SEEK = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]       state_q;
	logic             op_q;
	logic [15:0]      idx_q;
	logic             bit_q;
	logic             last_q;
	logic [15:0]      gmin_q;
	logic [POS_W-1:0] start_q;
	logic [WA_W-1:0]  w_q;
	word_t            lo_mask_q;
	word_t            rd_q;
	logic             res_found_q;
	logic [15:0]      res_idx_q;
	logic             out_valid_q;
	logic             seed_found_q;
	logic [15:0]      seed_index_q;

	word_t            mem [NUM_WORDS];

	logic             in_xfer;
	logic             out_free;
	logic             mem_we;
	logic             mem_re;
	logic [WA_W-1:0]  mem_addr;
	word_t            mem_wdata;
	word_t            bit_mask;
	word_t            scan_bits;
	logic [POS_W-1:0] found_pos;

	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign bit_mask  = word_t'(1) << idx_q[WORD_LOG-1:0];
	assign scan_bits = rd_q & lo_mask_q & ((w_q == LAST_WORD) ? TAIL_MASK : '1);
	assign found_pos = {w_q, first_set(scan_bits)};

	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = '0;
		mem_wdata = (rd_q & ~bit_mask) | ((op_q == OP_LOAD && bit_q) ? bit_mask : '0);
		unique case (state_q)
			S_IDLE: begin
				mem_re   = in_xfer;
				mem_addr = WA_W'(entry_index[15:WORD_LOG]);
			end
			S_WR: begin
				mem_we   = (POS_W'(idx_q) < MAX_POS);
				mem_addr = WA_W'(idx_q[15:WORD_LOG]);
			end
			S_SEEK: begin
				mem_re   = (start_q < MAX_POS);
				mem_addr = start_q[POS_W-1:WORD_LOG];
			end
			S_SCAN: begin
				mem_re   = (scan_bits == '0) && (w_q != LAST_WORD);
				mem_addr = w_q + WA_W'(1);
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr[ADDR_W-1:0]] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[mem_addr[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q   <= operation;
			idx_q  <= entry_index;
			bit_q  <= pending_bit;
			last_q <= last_of_group;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			gmin_q  <= '1;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_WR;
						if (operation == OP_MARK && entry_index < gmin_q) begin
							gmin_q <= entry_index;
						end
					end
				end
				S_WR: begin
					if (last_q) begin
						state_q <= S_SEEK;
						if (op_q == OP_MARK) begin
							gmin_q <= '1;
						end
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_SEEK: begin
					state_q <= (start_q < MAX_POS) ? S_SCAN : S_DONE;
				end
				S_SCAN: begin
					if (scan_bits != '0 || w_q == LAST_WORD) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_WR) begin
			start_q <= (op_q == OP_MARK) ? POS_W'(gmin_q) + POS_W'(1) : '0;
		end
		if (state_q == S_SEEK) begin
			w_q         <= start_q[POS_W-1:WORD_LOG];
			lo_mask_q   <= word_t'('1) << start_q[WORD_LOG-1:0];
			res_found_q <= 1'b0;
			res_idx_q   <= '0;
		end
		if (state_q == S_SCAN) begin
			if (scan_bits != '0) begin
				res_found_q <= 1'b1;
				res_idx_q   <= found_pos[15:0];
			end else begin
				w_q       <= w_q + WA_W'(1);
				lo_mask_q <= '1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			seed_found_q <= res_found_q;
			seed_index_q <= res_idx_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign seed_found = seed_found_q;
	assign seed_index = seed_index_q;

`ifndef SYNTHESIS
	// new result only comes out of the done state
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !$past(out_valid_q)) |-> ($past(state_q) == S_DONE))
		else $error("result appeared without a finished search");

	// scan never runs past the last bitmap word
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (w_q <= LAST_WORD))
		else $error("scan word out of range");

	// closing a mark group resets the running minimum
	a_gmin_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WR && op_q == OP_MARK && last_q) |=> (gmin_q == '1))
		else $error("group minimum not cleared after group end");

	// done with a free output always produces a result next cycle
	a_done_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> (out_valid_q && state_q == S_IDLE))
		else $error("finished result not delivered");

	// the map is never written during a search
	a_no_write_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEEK || state_q == S_SCAN) |-> !mem_we)
		else $error("bitmap written during search");
`endif

endmodule
